>>> rtl/pds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pds_pkg
// types and constants shared by the panel deploy sequencer modules
// ----------------------------------------------------------------------------
package pds_pkg;

    typedef enum logic [2:0] {
        ST_STANDBY  = 3'd0,
        ST_SELFTEST = 3'd1,
        ST_FAIL     = 3'd2,
        ST_READY    = 3'd3,
        ST_MAINT    = 3'd4,
        ST_OPER     = 3'd5,
        ST_EMERG    = 3'd6
    } t_sys_state;

    typedef enum logic [2:0] {
        MD_SAFE    = 3'd0,
        MD_CLOSED  = 3'd1,
        MD_EXTEND  = 3'd2,
        MD_OPEN    = 3'd3,
        MD_RETRACT = 3'd4
    } t_mode;

    // register indexes (word address bits)
    typedef enum logic [1:0] {
        REG_EMERG_LIMIT   = 2'd0,
        REG_REDUCED_LIMIT = 2'd1,
        REG_SELFTEST_TICK = 2'd2,
        REG_TRAVEL_LIMIT  = 2'd3
    } t_reg_idx;

    localparam logic [15:0] EMERG_LIMIT_RST   = 16'd200;
    localparam logic [15:0] REDUCED_LIMIT_RST = 16'd500;
    localparam logic [3:0]  SELFTEST_TICK_RST = 4'd5;
    localparam logic [6:0]  TRAVEL_LIMIT_RST  = 7'd20;

    localparam logic [4:0]         TICK_MAX = 5'd31;
    localparam logic signed [7:0]  POS_MAX  = 8'sd127;
    localparam logic signed [7:0]  POS_MIN  = -8'sd128;

    localparam int ITEM_W   = 19;

    // input item, switch_on in the lowest bit
    typedef struct packed {
        logic [15:0] power_level;
        logic        maintenance_request;
        logic        panel_command;
        logic        switch_on;
    } t_item;

    typedef struct packed {
        logic [15:0] emergency_power_limit;
        logic [15:0] reduced_power_limit;
        logic [3:0]  self_test_ticks;
        logic [6:0]  travel_limit;
    } t_cfg;

    // result item, system_state in the lowest bits
    typedef struct packed {
        logic               on_latched;
        logic               reduced_flag;
        logic signed [7:0]  panel_position;
        t_mode              panel_mode;
        t_sys_state         system_state;
    } t_status;

endpackage
`default_nettype wire

>>> rtl/panel_deploy_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// panel_deploy_sequencer
// solar panel deploy sequencer: system state machine with panel sub-machine
// ----------------------------------------------------------------------------
// Each item on the slave stream is one control tick (switch on, panel
// command, maintenance request, power reading) and produces exactly one
// status item on the master stream with the state after that tick. The
// block takes one item per clock cycle while the master side accepts; an
// item is captured in an input register, and when the output register is
// free or draining the tick logic runs and its status lands in the output
// register, where it is valid on the master side. The sequencer state is
// updated in the same cycle as the output register, so the next item always
// sees the previous item's result.
// Backpressure on the master side stalls the input register and then the
// slave side. The apb limits are meant to be written while the stream is idle.
// ----------------------------------------------------------------------------
module panel_deploy_sequencer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // apb configuration port
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // tick items in
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // switch_on[0], panel_command[1], maintenance_request[2], power_level[18:3]
    input  wire logic [23:0]   s_axis_tdata,
    // status items out
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // system_state[2:0], panel_mode[5:3], panel_position[13:6],
    // reduced_flag[14], on_latched[15]
    output logic [15:0]        m_axis_tdata
);

    pds_pkg::t_cfg     cfg;
    pds_pkg::t_item    r_item;
    pds_pkg::t_status  r_status;
    pds_pkg::t_status  next_status;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              advance;
    logic              in_take;

    // the tick runs when an item waits and the output register is free or draining
    assign advance       = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | advance;
    assign in_take       = s_axis_tvalid & s_axis_tready;

    pds_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pds_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_item),
        .i_cfg     (cfg),
        .o_next    (next_status)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= pds_pkg::t_item'(s_axis_tdata[pds_pkg::ITEM_W-1:0]);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_status <= next_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_status;

`ifndef SYNTH
    // a ticked item always shows up in the output register next cycle
    a_advance_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("ticked item did not reach output register");

    // a held input item is neither dropped nor overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_item)))
        else $error("waiting input item lost or changed");

    // the reduced flag never clears once set
    a_reduced_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status.reduced_flag && advance)
            |-> next_status.reduced_flag)
        else $error("reduced flag cleared");

    // operating in safe shutdown pins the panel at zero travel
    a_safe_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status.system_state == pds_pkg::ST_OPER
            && r_status.panel_mode == pds_pkg::MD_SAFE)
            |-> (r_status.panel_position == 8'sd0))
        else $error("panel moved in safe shutdown");
`endif

endmodule
`default_nettype wire

>>> rtl/pds_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pds_cfg_regs
// apb register bank holding the sequencer limits
// ----------------------------------------------------------------------------
module pds_cfg_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output pds_pkg::t_cfg      o_cfg
);

    pds_pkg::t_cfg r_cfg;
    pds_pkg::t_reg_idx idx;
    logic wr_en;

    assign pready = 1'b1;
    assign idx    = pds_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.emergency_power_limit <= pds_pkg::EMERG_LIMIT_RST;
            r_cfg.reduced_power_limit   <= pds_pkg::REDUCED_LIMIT_RST;
            r_cfg.self_test_ticks       <= pds_pkg::SELFTEST_TICK_RST;
            r_cfg.travel_limit          <= pds_pkg::TRAVEL_LIMIT_RST;
        end else if (wr_en) begin
            unique case (idx)
                pds_pkg::REG_EMERG_LIMIT:   r_cfg.emergency_power_limit <= pwdata[15:0];
                pds_pkg::REG_REDUCED_LIMIT: r_cfg.reduced_power_limit   <= pwdata[15:0];
                pds_pkg::REG_SELFTEST_TICK: r_cfg.self_test_ticks       <= pwdata[3:0];
                pds_pkg::REG_TRAVEL_LIMIT:  r_cfg.travel_limit          <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            pds_pkg::REG_EMERG_LIMIT:   prdata = {16'd0, r_cfg.emergency_power_limit};
            pds_pkg::REG_REDUCED_LIMIT: prdata = {16'd0, r_cfg.reduced_power_limit};
            pds_pkg::REG_SELFTEST_TICK: prdata = {28'd0, r_cfg.self_test_ticks};
            pds_pkg::REG_TRAVEL_LIMIT:  prdata = {25'd0, r_cfg.travel_limit};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/pds_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pds_core
// system and panel state registers with the per-tick next-state logic
// ----------------------------------------------------------------------------
module pds_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_advance,
    input  wire pds_pkg::t_item  i_item,
    input  wire pds_pkg::t_cfg   i_cfg,
    output pds_pkg::t_status     o_next
);

    pds_pkg::t_sys_state r_sys,  n_sys;
    pds_pkg::t_mode      r_mode, n_mode;
    logic signed [7:0]   r_pos,  n_pos;
    logic                r_reduced, n_reduced;
    logic                r_on,   n_on;
    logic [4:0]          r_tick, n_tick;

    logic signed [8:0]   step;
    logic signed [8:0]   ext_sum;
    logic signed [8:0]   ret_diff;
    logic signed [7:0]   ext_pos;
    logic signed [7:0]   ret_pos;
    logic                ext_open;
    logic [4:0]          tick_inc;

    // panel travel arithmetic, widened by one bit to catch saturation
    assign step     = r_reduced ? 9'sd1 : 9'sd2;
    assign ext_sum  = {r_pos[7], r_pos} + step;
    assign ret_diff = {r_pos[7], r_pos} - step;
    assign ext_pos  = (ext_sum > 9'sd127) ? pds_pkg::POS_MAX : ext_sum[7:0];
    assign ret_pos  = (ret_diff < -9'sd128) ? pds_pkg::POS_MIN : ret_diff[7:0];
    assign ext_open = (ext_pos > $signed({1'b0, i_cfg.travel_limit}))
                    || (ext_pos == pds_pkg::POS_MAX);
    assign tick_inc = (r_tick < pds_pkg::TICK_MAX) ? r_tick + 5'd1 : r_tick;

    always_comb begin
        n_sys     = r_sys;
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_reduced = r_reduced;
        n_tick    = r_tick;
        n_on      = r_on | i_item.switch_on;
        unique case (r_sys)
            pds_pkg::ST_EMERG: begin
                n_sys = pds_pkg::ST_STANDBY;
                n_on  = 1'b0;
            end
            pds_pkg::ST_OPER: begin
                case (r_mode)
                    pds_pkg::MD_CLOSED: begin
                        if (i_item.panel_command) n_mode = pds_pkg::MD_EXTEND;
                    end
                    pds_pkg::MD_OPEN: begin
                        if (!i_item.panel_command) n_mode = pds_pkg::MD_RETRACT;
                    end
                    pds_pkg::MD_EXTEND: begin
                        n_pos = ext_pos;
                        if (ext_open) n_mode = pds_pkg::MD_OPEN;
                    end
                    pds_pkg::MD_RETRACT: begin
                        n_pos = ret_pos;
                        if (ret_pos[7]) n_mode = pds_pkg::MD_CLOSED;
                    end
                    default: n_pos = 8'sd0;
                endcase
            end
            pds_pkg::ST_STANDBY: begin
                if (n_on) begin
                    n_sys  = pds_pkg::ST_SELFTEST;
                    n_tick = 5'd0;
                end
            end
            pds_pkg::ST_SELFTEST: begin
                if (i_item.power_level <= i_cfg.emergency_power_limit) begin
                    n_sys = pds_pkg::ST_EMERG;
                end else if (i_item.power_level <= i_cfg.reduced_power_limit) begin
                    n_sys = pds_pkg::ST_FAIL;
                end else begin
                    n_tick = tick_inc;
                    if (tick_inc > {1'b0, i_cfg.self_test_ticks}) n_sys = pds_pkg::ST_READY;
                end
            end
            pds_pkg::ST_FAIL: begin
                n_sys     = pds_pkg::ST_OPER;
                n_mode    = pds_pkg::MD_CLOSED;
                n_reduced = 1'b1;
            end
            pds_pkg::ST_READY: begin
                n_sys = i_item.maintenance_request ? pds_pkg::ST_MAINT : pds_pkg::ST_OPER;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys     <= pds_pkg::ST_STANDBY;
            r_mode    <= pds_pkg::MD_SAFE;
            r_pos     <= 8'sd0;
            r_reduced <= 1'b0;
            r_on      <= 1'b0;
            r_tick    <= 5'd0;
        end else if (i_advance) begin
            r_sys     <= n_sys;
            r_mode    <= n_mode;
            r_pos     <= n_pos;
            r_reduced <= n_reduced;
            r_on      <= n_on;
            r_tick    <= n_tick;
        end
    end

    always_comb begin
        o_next.system_state   = n_sys;
        o_next.panel_mode     = n_mode;
        o_next.panel_position = n_pos;
        o_next.reduced_flag   = n_reduced;
        o_next.on_latched     = n_on;
    end

endmodule
`default_nettype wire

>>> bench/tb_panel_deploy_sequencer.sv
// ----------------------------------------------------------------------------
// tb_panel_deploy_sequencer
// self-checking bench for the solar panel deploy sequencer
// ----------------------------------------------------------------------------
// Tick items are fed on the slave stream from a pending queue and every
// status item on the master stream is checked field by field against an
// in-bench model of the sequencer. Both stream sides idle at random. The
// limits are changed over apb between phases, while the stream is quiet.
// The self test loop (standby, self test, emergency) is exercised first
// under several limit settings. One bring-up route then leads into one of
// the terminal states, which the block never leaves without reset.
// ----------------------------------------------------------------------------
module tb_panel_deploy_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    // how the final bring-up leaves self test
    typedef enum {
        ROUTE_FAIL,
        ROUTE_MAINT,
        ROUTE_OPER
    } t_route;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // switch_on[0], panel_command[1], maintenance_request[2], power_level[18:3]
    logic [23:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // system_state[2:0], panel_mode[5:3], panel_position[13:6],
    // reduced_flag[14], on_latched[15]
    logic [15:0] m_axis_tdata;

    panel_deploy_sequencer dut (
        .i_clk,
        .i_rst_n,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow copy of the limit registers
    logic [15:0] lim_emerg   = pds_pkg::EMERG_LIMIT_RST;
    logic [15:0] lim_reduced = pds_pkg::REDUCED_LIMIT_RST;
    logic [3:0]  lim_ticks   = pds_pkg::SELFTEST_TICK_RST;
    logic [6:0]  lim_travel  = pds_pkg::TRAVEL_LIMIT_RST;

    // shadow copy of the sequencer state
    pds_pkg::t_sys_state seq_state   = pds_pkg::ST_STANDBY;
    pds_pkg::t_mode      seq_mode    = pds_pkg::MD_SAFE;
    logic signed [7:0]   seq_pos     = '0;
    logic                seq_reduced = 1'b0;
    logic                seq_on      = 1'b0;
    logic [4:0]          seq_ticks   = '0;

    pds_pkg::t_item   tick_queue[$];     // items not yet offered to the block
    pds_pkg::t_status status_queue[$];   // predicted status, oldest first
    pds_pkg::t_item   tx_item;

    int n_queued     = 0;
    int n_results    = 0;
    int n_mismatch   = 0;
    int n_cfg_writes = 0;
    int tx_wait      = 0;
    int tx_calm      = 0;
    int rx_wait      = 0;
    int rx_calm      = 0;

    t_route route;

    function automatic void note_mismatch(string what, int want, int got);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS) begin
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endfunction

    // idle cycles before the next item, with bursts of back-to-back items
    function automatic int pick_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic logic coin();
        return $urandom_range(0, 1) == 1;
    endfunction

    // one control tick of the sequencer; updates the shadow state
    function automatic pds_pkg::t_status advance_sequencer(pds_pkg::t_item it);
        pds_pkg::t_status st;
        int      step;
        int      p;
        step = seq_reduced ? 1 : 2;
        // latch first, so emergency can still clear it this tick
        if (it.switch_on) seq_on = 1'b1;
        case (seq_state)
            pds_pkg::ST_EMERG: begin
                seq_state = pds_pkg::ST_STANDBY;
                seq_on    = 1'b0;
            end
            pds_pkg::ST_OPER: begin
                if (seq_mode == pds_pkg::MD_CLOSED) begin
                    if (it.panel_command) seq_mode = pds_pkg::MD_EXTEND;
                end else if (seq_mode == pds_pkg::MD_OPEN) begin
                    if (!it.panel_command) seq_mode = pds_pkg::MD_RETRACT;
                end else if (seq_mode == pds_pkg::MD_EXTEND) begin
                    p = int'(seq_pos) + step;
                    if (p > int'(pds_pkg::POS_MAX)) p = int'(pds_pkg::POS_MAX);
                    // signed compare, and the top of the range also counts as open
                    if (p > int'(lim_travel) || p == int'(pds_pkg::POS_MAX))
                        seq_mode = pds_pkg::MD_OPEN;
                    seq_pos = p[7:0];
                end else if (seq_mode == pds_pkg::MD_RETRACT) begin
                    p = int'(seq_pos) - step;
                    if (p < int'(pds_pkg::POS_MIN)) p = int'(pds_pkg::POS_MIN);
                    if (p < 0) seq_mode = pds_pkg::MD_CLOSED;
                    seq_pos = p[7:0];
                end else begin
                    // safe shutdown pins the panel home
                    seq_pos = '0;
                end
            end
            pds_pkg::ST_STANDBY: begin
                if (seq_on) begin
                    seq_state = pds_pkg::ST_SELFTEST;
                    seq_ticks = '0;
                end
            end
            pds_pkg::ST_SELFTEST: begin
                if (it.power_level <= lim_emerg) begin
                    seq_state = pds_pkg::ST_EMERG;
                end else if (it.power_level <= lim_reduced) begin
                    seq_state = pds_pkg::ST_FAIL;
                end else begin
                    if (seq_ticks < pds_pkg::TICK_MAX) seq_ticks++;
                    if (seq_ticks > {1'b0, lim_ticks}) seq_state = pds_pkg::ST_READY;
                end
            end
            pds_pkg::ST_FAIL: begin
                seq_state   = pds_pkg::ST_OPER;
                seq_mode    = pds_pkg::MD_CLOSED;
                seq_reduced = 1'b1;
            end
            pds_pkg::ST_READY: begin
                seq_state = it.maintenance_request ? pds_pkg::ST_MAINT : pds_pkg::ST_OPER;
            end
            default: ;
        endcase
        st.system_state   = seq_state;
        st.panel_mode     = seq_mode;
        st.panel_position = seq_pos;
        st.reduced_flag   = seq_reduced;
        st.on_latched     = seq_on;
        return st;
    endfunction

    // ------------------------------------------------------------------------
    // slave side: predict on accept, then offer the next pending item
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : tx_side
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                status_queue.push_back(advance_sequencer(tx_item));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (tick_queue.size() > 0) begin
                    tx_item = tick_queue.pop_front();
                    s_axis_tdata  <= 24'(tx_item);
                    s_axis_tvalid <= 1'b1;
                    tx_wait = pick_wait(tx_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // master side: check each status item, then stall for a random while
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : rx_side
        pds_pkg::t_status got;
        pds_pkg::t_status want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = pds_pkg::t_status'(m_axis_tdata);
                n_results++;
                if (status_queue.size() == 0) begin
                    note_mismatch("status item with none predicted", 0, int'(m_axis_tdata));
                end else begin
                    want = status_queue.pop_front();
                    if (got.system_state !== want.system_state)
                        note_mismatch("system_state", int'(want.system_state),
                                      int'(got.system_state));
                    if (got.panel_mode !== want.panel_mode)
                        note_mismatch("panel_mode", int'(want.panel_mode),
                                      int'(got.panel_mode));
                    if (got.panel_position !== want.panel_position)
                        note_mismatch("panel_position", int'(want.panel_position),
                                      int'(got.panel_position));
                    if (got.reduced_flag !== want.reduced_flag)
                        note_mismatch("reduced_flag", int'(want.reduced_flag),
                                      int'(got.reduced_flag));
                    if (got.on_latched !== want.on_latched)
                        note_mismatch("on_latched", int'(want.on_latched),
                                      int'(got.on_latched));
                end
                rx_wait = pick_wait(rx_calm);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_axis_tready <= (rx_wait == 0);
        end
    end

    // ------------------------------------------------------------------------
    // apb access and limit programming
    // ------------------------------------------------------------------------
    task automatic apb_access(input pds_pkg::t_reg_idx idx, input logic wr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        // the transfer completes at the edge that sees pready
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write a limit, mirror it in the shadow copy and read it back
    task automatic set_limit(input pds_pkg::t_reg_idx idx, input logic [31:0] val);
        logic [31:0] mask;
        logic [31:0] rd;
        case (idx)
            pds_pkg::REG_EMERG_LIMIT: begin
                mask = 32'h0000_FFFF;
                lim_emerg = val[15:0];
            end
            pds_pkg::REG_REDUCED_LIMIT: begin
                mask = 32'h0000_FFFF;
                lim_reduced = val[15:0];
            end
            pds_pkg::REG_SELFTEST_TICK: begin
                mask = 32'h0000_000F;
                lim_ticks = val[3:0];
            end
            default: begin
                mask = 32'h0000_007F;
                lim_travel = val[6:0];
            end
        endcase
        apb_access(idx, 1'b1, val & mask, rd);
        apb_access(idx, 1'b0, '0, rd);
        if (rd !== (val & mask)) note_mismatch("register readback", int'(val & mask), int'(rd));
        n_cfg_writes++;
    endtask

    task automatic set_limits(input int unsigned emerg, input int unsigned reduced,
                              input int unsigned ticks, input int unsigned travel);
        set_limit(pds_pkg::REG_EMERG_LIMIT, emerg);
        set_limit(pds_pkg::REG_REDUCED_LIMIT, reduced);
        set_limit(pds_pkg::REG_SELFTEST_TICK, ticks);
        set_limit(pds_pkg::REG_TRAVEL_LIMIT, travel);
    endtask

    // ------------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------------
    task automatic queue_tick(input logic sw, input logic cmd, input logic maint,
                              input logic [15:0] pwr);
        pds_pkg::t_item it;
        it.switch_on           = sw;
        it.panel_command       = cmd;
        it.maintenance_request = maint;
        it.power_level         = pwr;
        tick_queue.push_back(it);
        n_queued++;
    endtask

    // a reading above both limits; only valid while such a reading exists
    function automatic logic [15:0] good_power();
        int unsigned hi;
        hi = (lim_emerg > lim_reduced) ? lim_emerg : lim_reduced;
        if ($urandom_range(0, 3) == 0) return 16'(hi + 1);
        return 16'($urandom_range(65535, hi + 1));
    endfunction

    function automatic logic [15:0] emergency_power();
        if ($urandom_range(0, 3) == 0) return lim_emerg;
        return 16'($urandom_range(0, lim_emerg));
    endfunction

    // standby, switch on, a few good readings short of ready, then a low
    // reading forces emergency and the next tick drops back to standby
    task automatic queue_selftest_abort();
        int unsigned hi;
        int unsigned goods;
        int unsigned idle_n;
        hi     = (lim_emerg > lim_reduced) ? lim_emerg : lim_reduced;
        idle_n = $urandom_range(0, 2);
        repeat (idle_n) queue_tick(1'b0, coin(), coin(), 16'($urandom));
        queue_tick(1'b1, coin(), coin(), 16'($urandom));
        goods = (hi < 65535) ? $urandom_range(0, lim_ticks) : 0;
        repeat (goods) queue_tick(coin(), coin(), coin(), good_power());
        queue_tick(coin(), coin(), coin(), emergency_power());
        queue_tick(coin(), coin(), coin(), 16'($urandom));
    endtask

    // from standby into a terminal state; needs emergency < reduced < 65535
    task automatic queue_bringup(input t_route r);
        int unsigned goods;
        logic [15:0] pwr;
        queue_tick(1'b1, coin(), coin(), 16'($urandom));
        if (r == ROUTE_FAIL) begin
            goods = $urandom_range(0, lim_ticks);
            repeat (goods) queue_tick(coin(), coin(), coin(), good_power());
            case ($urandom_range(0, 2))
                0:       pwr = lim_emerg + 16'd1;
                1:       pwr = lim_reduced;
                default: pwr = 16'($urandom_range(lim_emerg + 1, lim_reduced));
            endcase
            queue_tick(coin(), coin(), coin(), pwr);
        end else begin
            // one good reading past the tick limit reaches ready
            repeat (lim_ticks + 1) queue_tick(coin(), coin(), coin(), good_power());
            queue_tick(coin(), coin(), r == ROUTE_MAINT, 16'($urandom));
        end
    endtask

    // runs of steady panel command, mostly short, sometimes long
    task automatic queue_panel_moves(input int n);
        int   left;
        int   len;
        logic cmd;
        left = n;
        while (left > 0) begin
            cmd = coin();
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 12);
            if (len > left) len = left;
            repeat (len) queue_tick(coin(), cmd, coin(), 16'($urandom));
            left -= len;
        end
    endtask

    // wait until all queued items are answered and the stream has settled
    task automatic wait_idle();
        while (n_results < n_queued) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned e;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed pass at the reset limits (200 / 500 / 5 / 20)
        queue_tick(1'b0, 1'b1, 1'b1, 16'hFFFF);   // standby holds without switch on
        queue_tick(1'b0, 1'b0, 1'b0, 16'h0000);
        queue_tick(1'b1, 1'b0, 1'b0, 16'h0000);   // switch on enters self test
        queue_tick(1'b0, 1'b1, 1'b0, 16'd501);    // just above the reduced limit
        queue_tick(1'b1, 1'b1, 1'b1, 16'hFFFF);
        queue_tick(1'b0, 1'b0, 1'b1, 16'd200);    // emergency limit itself is low
        queue_tick(1'b1, 1'b1, 1'b1, 16'hFFFF);   // switch on in emergency is cleared
        queue_tick(1'b0, 1'b0, 1'b0, 16'd1234);
        queue_tick(1'b1, 1'b1, 1'b0, 16'd12345);
        queue_tick(1'b0, 1'b0, 1'b0, 16'h0000);   // zero power, emergency
        queue_tick(1'b0, 1'b0, 1'b0, 16'h0000);
        // good readings up to the tick limit do not yet pass self test
        queue_tick(1'b1, 1'b0, 1'b0, 16'h0000);
        repeat (5) queue_tick(1'b1, 1'b1, 1'b1, 16'hFFFF);
        queue_tick(1'b0, 1'b0, 1'b0, 16'd1);
        queue_tick(1'b0, 1'b1, 1'b1, 16'hAAAA);
        wait_idle();

        // self test loop under extreme and random limits
        set_limits(0, 0, 0, 1);
        repeat (12) queue_selftest_abort();
        wait_idle();
        set_limits(65535, 0, 15, 100);            // every reading is an emergency
        repeat (8) queue_selftest_abort();
        wait_idle();
        set_limits(0, 65535, 15, 1);              // zero power is an emergency, every other reading fails
        repeat (8) queue_selftest_abort();
        wait_idle();
        e = $urandom_range(0, 30000);
        set_limits(e, e + $urandom_range(0, 30000), $urandom_range(0, 15), 20);
        repeat (15) queue_selftest_abort();
        wait_idle();

        // bring-up into a terminal state, then panel motion
        if ($urandom_range(0, 7) == 0) begin
            route = ROUTE_MAINT;
        end else if ($urandom_range(0, 6) == 0) begin
            route = ROUTE_OPER;
        end else begin
            route = ROUTE_FAIL;
        end
        e = $urandom_range(0, 1000);
        set_limits(e, e + $urandom_range(1, 3000), $urandom_range(0, 15), 1);
        queue_bringup(route);
        queue_panel_moves(150);
        wait_idle();
        set_limit(pds_pkg::REG_TRAVEL_LIMIT, 100);
        queue_panel_moves(200);
        wait_idle();
        set_limit(pds_pkg::REG_TRAVEL_LIMIT, $urandom_range(1, 100));
        queue_panel_moves(150);
        wait_idle();

        if (status_queue.size() != 0)
            note_mismatch("status items never delivered", 0, status_queue.size());
        $display("covered %0d tick items, %0d status items and %0d limit writes",
                 n_queued, n_results, n_cfg_writes);
        $display("bring-up route %s, %0d mismatches", route.name(), n_mismatch);
        if (n_mismatch == 0) begin
            $display("tb_panel_deploy_sequencer OK");
        end else begin
            $display("tb_panel_deploy_sequencer NOT OK");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin : watchdog
        #2ms;
        $display("timeout waiting for status items");
        $display("tb_panel_deploy_sequencer NOT OK");
        $finish;
    end

endmodule
